// ===== hdl/hmt_pkg.sv =====
package hmt_pkg;

  localparam int ELEM_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 8;
  localparam int REG_BITS  = 64;
  localparam int IDX_BITS  = 3;
  localparam int WIDE_BITS = 3 * ELEM_BITS + 4;
  localparam int DIV_BITS  = 2 * ELEM_BITS + FRAC_BITS;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef enum logic [1:0] {
    ACT_POINT   = 2'd0,
    ACT_DIR     = 2'd1,
    ACT_COMPOSE = 2'd2,
    ACT_DET     = 2'd3
  } action_t;

  typedef struct packed {
    action_t          action;
    elem_t [3:0]      vec;
  } item_t;

  typedef struct packed {
    action_t          action;
    elem_t [3:0]      res;
    elem_t            det;
    logic             w_zero;
    logic             sat;
  } result_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};

  // round to nearest, ties up, then clip; returns {clipped, value}
  function automatic logic [ELEM_BITS:0] round_sat(input wide_t v, input int sh);
    wide_t t;
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = $signed({{(WIDE_BITS-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}});
    lo_lim = $signed({{(WIDE_BITS-ELEM_BITS+1){1'b1}}, {(ELEM_BITS-1){1'b0}}});
    t = (v + (wide_t'(1) <<< (sh - 1))) >>> sh;
    if (t > hi_lim) begin
      return {1'b1, ELEM_MAX};
    end else if (t < lo_lim) begin
      return {1'b1, ELEM_MIN};
    end
    return {1'b0, t[ELEM_BITS-1:0]};
  endfunction

endpackage

// ===== hdl/hmt_front.sv =====
module hmt_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  hmt_pkg::action_t        in_action,
  input  hmt_pkg::elem_t [3:0]    in_vec,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hmt_pkg::item_t          out_item
);

  localparam hmt_pkg::elem_t ONE = hmt_pkg::elem_t'(1 << hmt_pkg::FRAC_BITS);

  hmt_pkg::item_t entry;
  hmt_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  // fold the fourth operand: one for points, zero where unused
  always_comb begin
    entry.action = in_action;
    entry.vec    = in_vec;
    case (in_action)
      hmt_pkg::ACT_POINT:   entry.vec[3] = ONE;
      hmt_pkg::ACT_COMPOSE: entry.vec[3] = in_vec[3];
      default:              entry.vec[3] = '0;
    endcase
  end

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

endmodule

// ===== hdl/hmt_mac.sv =====
module hmt_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  hmt_pkg::item_t          in_item,
  input  hmt_pkg::elem_t [15:0]   matrix,
  output logic                    out_valid,
  output hmt_pkg::result_t        out_res
);

  localparam int EB = hmt_pkg::ELEM_BITS;
  localparam int PB = 2 * EB;
  localparam int FB = hmt_pkg::FRAC_BITS;
  localparam int DET_A [6] = '{0, 0, 4, 4, 8, 8};
  localparam int DET_B [6] = '{5, 9, 1, 9, 1, 5};
  localparam int DET_C [6] = '{10, 6, 10, 2, 6, 2};
  localparam logic [5:0] DET_NEG = 6'b100110;

  typedef logic signed [PB-1:0] prod_t;
  typedef logic signed [PB:0]   prodx_t;

  logic              s1_valid, s2_valid, s3_valid;
  hmt_pkg::action_t  s1_action, s2_action, s3_action;
  prod_t             s1_prod [4][4];
  prod_t             s1_ab [6];
  hmt_pkg::elem_t    s1_c [6];
  hmt_pkg::wide_t    s2_sum [4];
  prod_t             s2_ph [6];
  prodx_t            s2_pl [6];
  hmt_pkg::elem_t    s3_res [4];
  logic [3:0]        s3_sat;
  hmt_pkg::wide_t    s3_term [6];
  hmt_pkg::wide_t    dsum;
  logic [EB:0]       det_rs;
  logic [EB:0]       row_rs [4];
  hmt_pkg::wide_t    term [6];
  logic [3:0]        row_used;
  hmt_pkg::result_t  res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_rs[r] = hmt_pkg::round_sat(s2_sum[r], FB);
    end
    for (int k = 0; k < 6; k++) begin
      term[k] = (hmt_pkg::wide_t'(s2_ph[k]) <<< EB) + hmt_pkg::wide_t'(s2_pl[k]);
    end
  end

  always_comb begin
    dsum = '0;
    for (int k = 0; k < 6; k++) begin
      dsum = dsum + s3_term[k];
    end
    det_rs = hmt_pkg::round_sat(dsum, 2 * FB);
    case (s3_action)
      hmt_pkg::ACT_DIR: row_used = 4'b0111;
      hmt_pkg::ACT_DET: row_used = 4'b0000;
      default:          row_used = 4'b1111;
    endcase
    res_next.action = s3_action;
    res_next.w_zero = 1'b0;
    for (int r = 0; r < 4; r++) begin
      res_next.res[r] = row_used[r] ? s3_res[r] : '0;
    end
    if (s3_action == hmt_pkg::ACT_DET) begin
      res_next.det = det_rs[EB-1:0];
      res_next.sat = det_rs[EB];
    end else begin
      res_next.det = '0;
      res_next.sat = |(s3_sat & row_used);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action <= in_item.action;
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 4; i++) begin
          s1_prod[r][i] <= matrix[i*4+r] * in_item.vec[i];
        end
      end
      for (int k = 0; k < 6; k++) begin
        s1_ab[k] <= matrix[DET_A[k]] * matrix[DET_B[k]];
        s1_c[k]  <= matrix[DET_C[k]];
      end

      s2_action <= s1_action;
      for (int r = 0; r < 4; r++) begin
        s2_sum[r] <= hmt_pkg::wide_t'(s1_prod[r][0]) + hmt_pkg::wide_t'(s1_prod[r][1])
                   + hmt_pkg::wide_t'(s1_prod[r][2]) + hmt_pkg::wide_t'(s1_prod[r][3]);
      end
      for (int k = 0; k < 6; k++) begin
        s2_ph[k] <= $signed(s1_ab[k][PB-1:EB]) * s1_c[k];
        s2_pl[k] <= $signed({1'b0, s1_ab[k][EB-1:0]}) * s1_c[k];
      end

      s3_action <= s2_action;
      for (int r = 0; r < 4; r++) begin
        s3_res[r] <= row_rs[r][EB-1:0];
        s3_sat[r] <= row_rs[r][EB];
      end
      for (int k = 0; k < 6; k++) begin
        s3_term[k] <= DET_NEG[k] ? -term[k] : term[k];
      end

      out_res <= res_next;
    end
  end

endmodule

// ===== hdl/hmt_div.sv =====
module hmt_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  hmt_pkg::result_t        in_res,
  output logic                    out_valid,
  output hmt_pkg::result_t        out_res
);

  localparam int EB = hmt_pkg::ELEM_BITS;
  localparam int FB = hmt_pkg::FRAC_BITS;
  localparam int DW = hmt_pkg::DIV_BITS;
  localparam int NS = EB;

  typedef logic [DW-1:0] rem_t;
  typedef logic [EB-1:0] mag_t;

  logic              st_valid [NS+1];
  hmt_pkg::result_t  st_side [NS+1];
  logic              st_go [NS+1];
  mag_t              st_dvs [NS+1];
  rem_t              st_rem [NS+1][3];
  mag_t              st_quo [NS+1][3];
  logic              st_neg [NS+1][3];
  logic              st_ovf [NS+1][3];

  hmt_pkg::result_t  side0;
  logic              go0;
  mag_t              magw;
  mag_t              magx [3];
  rem_t              rem0 [3];
  logic [2:0]        lane_sat;

  always_comb begin
    go0   = (in_res.action == hmt_pkg::ACT_POINT) && (in_res.res[3] != '0);
    magw  = in_res.res[3][EB-1] ? mag_t'(-in_res.res[3]) : mag_t'(in_res.res[3]);
    side0 = in_res;
    if (in_res.action == hmt_pkg::ACT_POINT) begin
      side0.res[3] = '0;
      side0.w_zero = in_res.res[3] == '0;
    end
    for (int l = 0; l < 3; l++) begin
      magx[l] = in_res.res[l][EB-1] ? mag_t'(-in_res.res[l]) : mag_t'(in_res.res[l]);
      rem0[l] = rem_t'(magx[l]) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_side[0] <= side0;
      st_go[0]   <= go0;
      st_dvs[0]  <= magw;
      for (int l = 0; l < 3; l++) begin
        st_rem[0][l] <= rem0[l];
        st_quo[0][l] <= '0;
        st_neg[0][l] <= in_res.res[l][EB-1] ^ in_res.res[3][EB-1];
        st_ovf[0][l] <= rem0[l] >= (rem_t'(magw) << EB);
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = EB - 1 - s;
    rem_t cmp;
    assign cmp = rem_t'(st_dvs[s]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s+1] <= 1'b0;
      end else if (adv) begin
        st_valid[s+1] <= st_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_side[s+1] <= st_side[s];
        st_go[s+1]   <= st_go[s];
        st_dvs[s+1]  <= st_dvs[s];
        for (int l = 0; l < 3; l++) begin
          st_neg[s+1][l] <= st_neg[s][l];
          st_ovf[s+1][l] <= st_ovf[s][l];
          if (st_rem[s][l] >= cmp) begin
            st_rem[s+1][l]    <= st_rem[s][l] - cmp;
            st_quo[s+1][l]    <= st_quo[s][l] | (mag_t'(1) << B);
          end else begin
            st_rem[s+1][l] <= st_rem[s][l];
            st_quo[s+1][l] <= st_quo[s][l];
          end
        end
      end
    end
  end

  always_comb begin
    out_valid = st_valid[NS];
    out_res   = st_side[NS];
    lane_sat  = '0;
    if (st_go[NS]) begin
      for (int l = 0; l < 3; l++) begin
        if (st_ovf[NS][l]) begin
          lane_sat[l]   = 1'b1;
          out_res.res[l] = st_neg[NS][l] ? hmt_pkg::ELEM_MIN : hmt_pkg::ELEM_MAX;
        end else if (st_neg[NS][l]) begin
          if (st_quo[NS][l] > mag_t'(hmt_pkg::ELEM_MIN)) begin
            lane_sat[l]    = 1'b1;
            out_res.res[l] = hmt_pkg::ELEM_MIN;
          end else begin
            out_res.res[l] = -$signed(st_quo[NS][l]);
          end
        end else if (st_quo[NS][l][EB-1]) begin
          lane_sat[l]    = 1'b1;
          out_res.res[l] = hmt_pkg::ELEM_MAX;
        end else begin
          out_res.res[l] = $signed(st_quo[NS][l]);
        end
      end
    end
    out_res.sat = st_side[NS].sat | (|lane_sat);
  end

endmodule

// ===== hdl/homogeneous_matrix_transform_core.sv =====
// channel   direction  fields (low bit first)
// s_*       in         tuser: action[1:0]; tdata: vec_x, vec_y, vec_z, vec_w
// m_*       out        tuser: w_zero, saturated; tdata: res_x, res_y, res_z, res_w, det_value
// cfg_*     in         cfg_index[2:0], cfg_data[63:0]; cfg_ready is always high
//
// One word per cycle sustained while the output is not stalled; an accepted word passes
// through the multiply/sum/round pipe (the input queue feeds its first stage directly),
// the bit-per-stage divider and the output register before it raises m_tvalid.
// Reset (rst, synchronous) loads the identity matrix and empties all stages.
// A stalled output freezes the whole back pipe; the two-word input queue keeps taking words until it is full.
module homogeneous_matrix_transform_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // vec_x, vec_y, vec_z, vec_w
  input  logic [1:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // res_x, res_y, res_z, res_w, det_value
  output logic [1:0]   m_tuser,   // w_zero, saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int EB = hmt_pkg::ELEM_BITS;
  localparam logic [63:0] ONE_LO = 64'(1) << hmt_pkg::FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  logic [hmt_pkg::REG_BITS-1:0] cfg_regs [hmt_pkg::NUM_REGS];
  hmt_pkg::elem_t [15:0]  matrix;
  hmt_pkg::elem_t [3:0]   in_vec;
  hmt_pkg::item_t         q_item;
  hmt_pkg::result_t       mac_res;
  hmt_pkg::result_t       div_res;
  logic                   q_valid;
  logic                   mac_valid;
  logic                   div_valid;
  logic                   adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hmt_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= '0;
      end
      cfg_regs[0] <= ONE_LO;
      cfg_regs[2] <= ONE_HI;
      cfg_regs[5] <= ONE_LO;
      cfg_regs[7] <= ONE_HI;
    end else if (cfg_valid) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_elem
    assign matrix[k] = cfg_regs[(k/4)*2 + (k%4)/2][(k%2)*32 +: EB];
  end

  for (genvar i = 0; i < 4; i++) begin : g_vec
    assign in_vec[i] = s_tdata[i*32 +: EB];
  end

  assign adv = !m_tvalid || m_tready;

  hmt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (hmt_pkg::action_t'(s_tuser)),
    .in_vec    (in_vec),
    .out_valid (q_valid),
    .out_ready (adv),
    .out_item  (q_item)
  );

  hmt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .matrix    (matrix),
    .out_valid (mac_valid),
    .out_res   (mac_res)
  );

  hmt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mac_valid),
    .in_res    (mac_res),
    .out_valid (div_valid),
    .out_res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {32'(div_res.det), 32'(div_res.res[3]), 32'(div_res.res[2]),
                  32'(div_res.res[1]), 32'(div_res.res[0])};
      m_tuser <= {div_res.sat, div_res.w_zero};
    end
  end

  a_wzero_no_w: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[127:96] == 32'd0)
    else $error("w_zero word carries a nonzero res_w");

  a_det_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[159:128] != 32'd0 |-> m_tdata[127:0] == 128'd0 && !m_tuser[0])
    else $error("determinant word carries row results");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(mac_res) && $stable(mac_valid))
    else $error("back pipe moved during output stall");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
    logic signed [31:0] det_value;
    logic               w_zero;
    logic               saturated;
  } xform_t;

  typedef logic signed [127:0] acc_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [127:0]  s_tdata;
  logic [1:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  logic [159:0]  m_tdata;
  logic [1:0]    m_tuser;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [2:0]    cfg_index;
  logic [63:0]   cfg_data;

  logic [63:0]   matrix_regs [hmt_pkg::NUM_REGS];
  xform_t        pending_results [$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_stall_pct;

  homogeneous_matrix_transform_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic acc_t element(int col, int row);
    logic [63:0] r;
    logic signed [31:0] e;
    r = matrix_regs[col * 2 + row / 2];
    e = (row % 2) ? r[63:32] : r[31:0];
    return acc_t'(e);
  endfunction

  function automatic logic signed [31:0] round_clip(acc_t v, int sh, inout logic sat);
    acc_t t;
    t = (v + (acc_t'(1) <<< (sh - 1))) >>> sh;
    if (t > acc_t'(64'sd2147483647)) begin
      sat = 1'b1;
      return hmt_pkg::ELEM_MAX;
    end else if (t < -acc_t'(64'sd2147483648)) begin
      sat = 1'b1;
      return hmt_pkg::ELEM_MIN;
    end
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] divide_by_w(logic signed [31:0] x,
                                                     logic signed [31:0] w,
                                                     inout logic sat);
    longint xs;
    longint ws;
    longint unsigned q;
    longint qn;
    xs = x;
    ws = w;
    q = ((xs < 0 ? -xs : xs) << hmt_pkg::FRAC_BITS) / (ws < 0 ? -ws : ws);
    if ((xs < 0) != (ws < 0)) begin
      if (q > 64'd2147483648) begin
        sat = 1'b1;
        return hmt_pkg::ELEM_MIN;
      end
      qn = -longint'(q);
      return qn[31:0];
    end
    if (q > 64'd2147483647) begin
      sat = 1'b1;
      return hmt_pkg::ELEM_MAX;
    end
    return q[31:0];
  endfunction

  function automatic xform_t predict_transform(hmt_pkg::action_t act, logic [127:0] vec);
    xform_t e;
    acc_t v [4];
    acc_t s;
    logic signed [31:0] r [4];
    logic sat;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v[i] = acc_t'($signed(vec[i*32 +: 32]));
      r[i] = '0;
    end
    e.det_value = '0;
    e.w_zero = 1'b0;
    case (act)
      hmt_pkg::ACT_POINT: begin
        for (int row = 0; row < 4; row++) begin
          s = element(3, row) * acc_t'(1 << hmt_pkg::FRAC_BITS);
          for (int i = 0; i < 3; i++) s += element(i, row) * v[i];
          r[row] = round_clip(s, hmt_pkg::FRAC_BITS, sat);
        end
        if (r[3] == 0) begin
          e.w_zero = 1'b1;
        end else begin
          for (int row = 0; row < 3; row++) r[row] = divide_by_w(r[row], r[3], sat);
        end
        r[3] = '0;
      end
      hmt_pkg::ACT_DIR: begin
        for (int row = 0; row < 3; row++) begin
          s = '0;
          for (int i = 0; i < 3; i++) s += element(i, row) * v[i];
          r[row] = round_clip(s, hmt_pkg::FRAC_BITS, sat);
        end
      end
      hmt_pkg::ACT_COMPOSE: begin
        for (int row = 0; row < 4; row++) begin
          s = '0;
          for (int i = 0; i < 4; i++) s += element(i, row) * v[i];
          r[row] = round_clip(s, hmt_pkg::FRAC_BITS, sat);
        end
      end
      default: begin
        s = element(0, 0) * element(1, 1) * element(2, 2)
          - element(0, 0) * element(2, 1) * element(1, 2)
          - element(1, 0) * element(0, 1) * element(2, 2)
          + element(1, 0) * element(2, 1) * element(0, 2)
          + element(2, 0) * element(0, 1) * element(1, 2)
          - element(2, 0) * element(1, 1) * element(0, 2);
        e.det_value = round_clip(s, 2 * hmt_pkg::FRAC_BITS, sat);
      end
    endcase
    e.res_x = r[0];
    e.res_y = r[1];
    e.res_z = r[2];
    e.res_w = r[3];
    e.saturated = sat;
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    xform_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: %h", m_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[31:0] !== exp_r.res_x) begin
          $error("res_x expected %h actual %h", exp_r.res_x, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[63:32] !== exp_r.res_y) begin
          $error("res_y expected %h actual %h", exp_r.res_y, m_tdata[63:32]);
          fail_count++;
        end
        if (m_tdata[95:64] !== exp_r.res_z) begin
          $error("res_z expected %h actual %h", exp_r.res_z, m_tdata[95:64]);
          fail_count++;
        end
        if (m_tdata[127:96] !== exp_r.res_w) begin
          $error("res_w expected %h actual %h", exp_r.res_w, m_tdata[127:96]);
          fail_count++;
        end
        if (m_tdata[159:128] !== exp_r.det_value) begin
          $error("det_value expected %h actual %h", exp_r.det_value, m_tdata[159:128]);
          fail_count++;
        end
        if (m_tuser[0] !== exp_r.w_zero) begin
          $error("w_zero expected %b actual %b", exp_r.w_zero, m_tuser[0]);
          fail_count++;
        end
        if (m_tuser[1] !== exp_r.saturated) begin
          $error("saturated expected %b actual %b", exp_r.saturated, m_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(hmt_pkg::action_t act, logic [127:0] vec);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= vec;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_transform(act, vec));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic load_matrix(logic [63:0] regs [hmt_pkg::NUM_REGS]);
    wait_idle();
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= regs[i];
      do @(posedge clk); while (!cfg_ready);
      matrix_regs[i] = regs[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'h0;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [127:0] rand_vec();
    logic [127:0] v;
    for (int i = 0; i < 4; i++) v[i*32 +: 32] = rand_elem();
    return v;
  endfunction

  task automatic load_random_matrix(bit affine, bit flat_w);
    logic [63:0] regs [hmt_pkg::NUM_REGS];
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = {rand_elem(), rand_elem()};
    if (affine || flat_w) begin
      for (int c = 0; c < 4; c++) regs[c * 2 + 1][63:32] = '0;
      if (affine) regs[7][63:32] = $signed($urandom_range(4 << 16)) - (2 << 16);
    end
    load_matrix(regs);
  endtask

  task automatic test_directed();
    logic [63:0] regs [hmt_pkg::NUM_REGS];
    for (int a = 0; a < 4; a++) begin
      send_word(hmt_pkg::action_t'(a),
                {32'h0004_0000, 32'hfffe_0000, 32'h0001_8000, 32'h0003_0000});
      send_word(hmt_pkg::action_t'(a), {4{32'h7fff_ffff}});
      send_word(hmt_pkg::action_t'(a), {4{32'h8000_0000}});
      send_word(hmt_pkg::action_t'(a), '0);
    end
    send_word(hmt_pkg::ACT_DIR, {32'h0, 32'h0, 32'h0, 32'hffff_ffff});
    // zero w row and a row-3 matrix giving ties and huge quotients
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = 64'h0;
    regs[0] = {32'h0, 32'h0000_8000};
    regs[2] = {32'h0, 32'h0001_0000};
    load_matrix(regs);
    send_word(hmt_pkg::ACT_POINT, {32'h0, 32'h0, 32'h0001_0000, 32'h0000_0001});
    send_word(hmt_pkg::ACT_POINT, {32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff});
    send_word(hmt_pkg::ACT_DET, '0);
    regs[7] = {32'h0000_0001, 32'h0};
    regs[6] = {32'h0, 32'h7fff_ffff};
    load_matrix(regs);
    send_word(hmt_pkg::ACT_POINT, {32'h0, 32'h0, 32'h0, 32'h0});
    send_word(hmt_pkg::ACT_POINT, {32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000});
    regs[7] = {32'hffff_ffff, 32'h0};
    load_matrix(regs);
    send_word(hmt_pkg::ACT_POINT, {32'h0, 32'h0, 32'h0, 32'h8000_0000});
  endtask

  task automatic test_random(int words);
    for (int n = 0; n < words; n++) begin
      if (n % 40 == 0) load_random_matrix($urandom_range(2) == 0, $urandom_range(5) == 0);
      send_word(hmt_pkg::action_t'($urandom_range(3)), rand_vec());
    end
  endtask

  task automatic test_extreme_matrices();
    logic [63:0] regs [hmt_pkg::NUM_REGS];
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = 64'h0;
    load_matrix(regs);
    for (int a = 0; a < 4; a++) send_word(hmt_pkg::action_t'(a), rand_vec());
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = '1;
    load_matrix(regs);
    for (int a = 0; a < 4; a++) send_word(hmt_pkg::action_t'(a), rand_vec());
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = 64'h7fff_ffff_7fff_ffff;
    load_matrix(regs);
    for (int a = 0; a < 4; a++) send_word(hmt_pkg::action_t'(a), rand_vec());
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) regs[i] = 64'h8000_0000_8000_0000;
    load_matrix(regs);
    for (int a = 0; a < 4; a++) send_word(hmt_pkg::action_t'(a), rand_vec());
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    send_idle_pct = 8;
    recv_stall_pct = 59;
    for (int i = 0; i < hmt_pkg::NUM_REGS; i++) matrix_regs[i] = 64'h0;
    matrix_regs[0] = 64'h0000_0000_0001_0000;
    matrix_regs[2] = 64'h0001_0000_0000_0000;
    matrix_regs[5] = 64'h0000_0000_0001_0000;
    matrix_regs[7] = 64'h0001_0000_0000_0000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_matrices();
    test_random(130);
    send_idle_pct = 59;
    recv_stall_pct = 8;
    test_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(130);
    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hmt_pkg.sv
hdl/hmt_front.sv
hdl/hmt_mac.sv
hdl/hmt_div.sv
hdl/homogeneous_matrix_transform_core.sv
sim/tb_top.sv
